### rtl/poi_pkg.sv
// package for the planar odometry integrator
// types, constants and the cordic angle table; no dependencies
package poi_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = 5;
  localparam int VecW = 36;
  localparam int ProdW = VecW + 32;
  localparam int HiW = VecW + 1;
  localparam int SumW = VecW + 9;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic [31:0] YawScale = 32'd2935890503;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] side_speed;
    logic signed [15:0] yaw_rate;
    logic [15:0]        interval;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic [31:0]        heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROT1, ST_GAIN1, ST_SCALE, ST_YAW, ST_ROT2, ST_GAIN2, ST_DONE
  } state_t;

  function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
    case (i)
      5'd0: atan_entry = 32'd536870912;
      5'd1: atan_entry = 32'd316933406;
      5'd2: atan_entry = 32'd167458907;
      5'd3: atan_entry = 32'd85004756;
      5'd4: atan_entry = 32'd42667331;
      5'd5: atan_entry = 32'd21354465;
      5'd6: atan_entry = 32'd10679838;
      5'd7: atan_entry = 32'd5340245;
      5'd8: atan_entry = 32'd2670163;
      5'd9: atan_entry = 32'd1335087;
      5'd10: atan_entry = 32'd667544;
      5'd11: atan_entry = 32'd333772;
      5'd12: atan_entry = 32'd166886;
      5'd13: atan_entry = 32'd83443;
      5'd14: atan_entry = 32'd41722;
      5'd15: atan_entry = 32'd20861;
      5'd16: atan_entry = 32'd10430;
      5'd17: atan_entry = 32'd5215;
      5'd18: atan_entry = 32'd2608;
      5'd19: atan_entry = 32'd1304;
      5'd20: atan_entry = 32'd652;
      5'd21: atan_entry = 32'd326;
      5'd22: atan_entry = 32'd163;
      5'd23: atan_entry = 32'd81;
      default: atan_entry = 32'd0;
    endcase
  endfunction

endpackage

### rtl/poi_cordic.sv
// one cordic rotation step per cycle, shared by the velocity and quaternion passes,
// and a byte-serial multiplier for the gain, interval and yaw products; uses poi_pkg
module poi_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [poi_pkg::VecW-1:0] x_in,
  input  logic signed [poi_pkg::VecW-1:0] y_in,
  input  logic [31:0] angle,
  output logic done,
  output logic signed [poi_pkg::VecW-1:0] x_out,
  output logic signed [poi_pkg::VecW-1:0] y_out
);
  import poi_pkg::*;

  logic signed [VecW-1:0] x, y;
  logic signed [32:0] z;
  logic [StepW-1:0] step;
  logic [1:0] quad;
  logic [31:0] resid;
  logic running;

  assign quad = 2'((angle + 32'h2000_0000) >> 30);
  assign resid = angle - {quad, 30'd0};
  assign done = running && (step == StepW'(CordicSteps - 1));
  assign x_out = (z[32]) ? x + (y >>> step) : x - (y >>> step);
  assign y_out = (z[32]) ? y - (x >>> step) : y + (x >>> step);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      step <= '0;
      z <= {resid[31], resid};
      case (quad)
        2'd1: begin x <= -y_in; y <= x_in; end
        2'd2: begin x <= -x_in; y <= -y_in; end
        2'd3: begin x <= y_in; y <= -x_in; end
        default: begin x <= x_in; y <= y_in; end
      endcase
    end else if (running) begin
      x <= x_out;
      y <= y_out;
      z <= z[32] ? z + 33'(atan_entry(step)) : z - 33'(atan_entry(step));
      step <= step + 1'b1;
      if (done) running <= 1'b0;
    end
  end
endmodule

module poi_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [poi_pkg::VecW-1:0] a,
  input  logic [31:0] b,
  output logic done,
  output logic signed [poi_pkg::ProdW-1:0] p
);
  import poi_pkg::*;

  logic signed [VecW-1:0] a_r;
  logic [31:0] b_r;
  logic signed [HiW-1:0] hi;
  logic [31:0] lo;
  logic signed [SumW-1:0] part, sum;
  logic [1:0] cnt;
  logic running;

  // low digit of b times a, added to the high half; low bytes shift out into lo
  assign part = SumW'(a_r) * SumW'($signed({1'b0, b_r[7:0]}));
  assign sum = SumW'(hi) + part;
  assign p = $signed({hi[VecW-1:0], lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= running && (cnt == 2'd3);
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
        a_r <= a;
        b_r <= b;
        hi <= '0;
        lo <= '0;
      end else if (running) begin
        hi <= HiW'(sum >>> 8);
        lo <= {sum[7:0], lo[31:8]};
        b_r <= b_r >> 8;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) running <= 1'b0;
      end
    end
  end
endmodule

### rtl/planar_odometry_integrator_top.sv
// planar odometry integrator top level: handshakes, sequencer, accumulators
// uses poi_pkg, poi_cordic and poi_mul
//
// channel   dir  payload            handshake
// in        in   poi_pkg::in_word_t  in_valid / in_stall
// out       out  poi_pkg::out_word_t out_valid / out_stall
//
// a word is taken only after the previous result has loaded: two 16-step passes of the
// shared cordic unit, the ST_YAW state to start the second pass, and three multiply phases
// (byte-serial, four digits), the yaw products running beside the first two phases.
// in_stall is high until the result register loads.
// a stalled full result register holds the sequencer; rst clears position, heading, handshakes.
module planar_odometry_integrator_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  poi_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output poi_pkg::out_word_t out_data
);
  import poi_pkg::*;

  state_t state, state_next;
  in_word_t cur;
  logic entry;
  logic [47:0] acc_x, acc_y;
  logic [31:0] heading;
  logic signed [VecW-1:0] vx, vy;
  logic signed [31:0] yaw_p;

  logic c_start, c_done;
  logic signed [VecW-1:0] c_xin, c_yin, c_xo, c_yo;
  logic [31:0] c_ang;

  logic m_start, mz_start, mx_done, my_done, mz_done, phase_done;
  logic [31:0] mxy_b, mz_b;
  logic signed [VecW-1:0] mz_a;
  logic signed [ProdW-1:0] mx_p, my_p, mz_p;

  // gain products, one per component
  logic signed [ProdW-1:0] gx, gy;
  logic signed [VecW-1:0] rx, ry;
  logic signed [ProdW-1:0] dxp, dyp, yround;
  logic [47:0] dx, dy;
  logic [31:0] ymag;
  logic [31:0] yinc;
  logic signed [VecW-1:0] qz_r, qw_r;
  logic out_load;

  function automatic logic signed [15:0] sat16(input logic signed [VecW-1:0] v);
    logic signed [VecW-1:0] r;
    r = (v + 36'sd8192) >>> 14;
    if (r > 36'sd32767) sat16 = 16'sh7fff;
    else if (r < -36'sd32768) sat16 = 16'sh8000;
    else sat16 = r[15:0];
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign c_start = (state == ST_IDLE && in_valid) || (state == ST_YAW);
  assign c_xin = (state == ST_YAW) ? 36'sd536870912 : 36'(in_data.forward_speed) <<< 14;
  assign c_yin = (state == ST_YAW) ? '0 : 36'(in_data.side_speed) <<< 14;
  assign c_ang = (state == ST_YAW) ? {1'b0, heading[31:1]} : heading;

  poi_cordic u_cordic (
    .clk(clk), .rst(rst), .start(c_start), .x_in(c_xin), .y_in(c_yin), .angle(c_ang),
    .done(c_done), .x_out(c_xo), .y_out(c_yo)
  );

  // multiplies start in the first cycle of their state
  assign m_start = entry && (state inside {ST_GAIN1, ST_SCALE, ST_GAIN2});
  assign mz_start = entry && (state inside {ST_GAIN1, ST_SCALE});
  assign phase_done = mx_done && my_done && (mz_done || state == ST_GAIN2);
  assign mxy_b = (state == ST_SCALE) ? {16'd0, cur.interval} : $unsigned(CordicGain);
  assign mz_a = (state == ST_SCALE) ? $signed(VecW'(ymag)) : VecW'(cur.yaw_rate);
  assign mz_b = (state == ST_SCALE) ? YawScale : {16'd0, cur.interval};

  poi_mul u_mul_x (
    .clk(clk), .rst(rst), .start(m_start), .a(vx), .b(mxy_b), .done(mx_done), .p(mx_p)
  );

  poi_mul u_mul_y (
    .clk(clk), .rst(rst), .start(m_start), .a(vy), .b(mxy_b), .done(my_done), .p(my_p)
  );

  poi_mul u_mul_z (
    .clk(clk), .rst(rst), .start(mz_start), .a(mz_a), .b(mz_b), .done(mz_done), .p(mz_p)
  );

  assign gx = mx_p + (ProdW'(1) <<< 29);
  assign gy = my_p + (ProdW'(1) <<< 29);
  assign rx = VecW'(gx >>> 30);
  assign ry = VecW'(gy >>> 30);
  assign dxp = mx_p + ProdW'(8192);
  assign dyp = my_p + ProdW'(8192);
  assign dx = 48'(dxp >>> 14);
  assign dy = 48'(dyp >>> 14);
  assign ymag = yaw_p[31] ? 32'(-yaw_p) : 32'(yaw_p);
  assign yround = mz_p + (ProdW'(1) <<< 31);
  assign yinc = yround[63:32];
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ROT1;
      ST_ROT1:  if (c_done) state_next = ST_GAIN1;
      ST_GAIN1: if (phase_done) state_next = ST_SCALE;
      ST_SCALE: if (phase_done) state_next = ST_YAW;
      ST_YAW:   state_next = ST_ROT2;
      ST_ROT2:  if (c_done) state_next = ST_GAIN2;
      ST_GAIN2: if (phase_done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry <= 1'b0;
      acc_x <= '0;
      acc_y <= '0;
      heading <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      entry <= (state_next != state);
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        ST_IDLE: if (in_valid) cur <= in_data;
        ST_ROT1: if (c_done) begin vx <= c_xo; vy <= c_yo; end
        ST_GAIN1: if (phase_done) begin
          vx <= rx;
          vy <= ry;
          yaw_p <= mz_p[31:0];
        end
        ST_SCALE: if (phase_done) begin
          acc_x <= acc_x + dx;
          acc_y <= acc_y + dy;
          heading <= yaw_p[31] ? heading - yinc : heading + yinc;
        end
        ST_ROT2: if (c_done) begin vx <= c_xo; vy <= c_yo; end
        ST_GAIN2: if (phase_done) begin qw_r <= rx; qz_r <= ry; end
        ST_DONE: if (out_load) begin
          out_data.position_x <= acc_x;
          out_data.position_y <= acc_y;
          out_data.heading_angle <= heading;
          out_data.quat_z <= sat16(qz_r);
          out_data.quat_w <= sat16(qw_r);
        end
        default: ;
      endcase
    end
  end
endmodule
